@@ sv/rna_pkg.sv @@
package rna_pkg;

	typedef enum logic [3:0] {
		MODE_ADD    = 4'd0,
		MODE_SUB    = 4'd1,
		MODE_MUL    = 4'd2,
		MODE_DIV    = 4'd3,
		MODE_REM    = 4'd4,
		MODE_TRUNC  = 4'd5,
		MODE_CEIL   = 4'd6,
		MODE_REDUCE = 4'd7,
		MODE_ABS    = 4'd8,
		MODE_NEG    = 4'd9,
		MODE_INV    = 4'd10
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_RUN,
		ST_SAVE,
		ST_FINISH
	} state_t;

	// shared serial unit operations
	typedef enum logic [2:0] {
		K_MUL,
		K_SDIV,
		K_SREM,
		K_UREM,
		K_QDIV
	} kind_t;

	typedef enum logic [2:0] {
		SRC_AN,
		SRC_AD,
		SRC_BN,
		SRC_BD,
		SRC_T0,
		SRC_T1
	} src_t;

	typedef enum logic [1:0] {
		D_T0,
		D_T1,
		D_T2,
		D_GCD
	} dest_t;

	typedef struct packed {
		logic  load;
		logic  issue;
		logic  run;
		logic  save;
		logic  finish;
		logic  err;
		mode_t mode;
		kind_t kind;
		src_t  sa;
		src_t  sb;
		dest_t dest;
	} cmd_t;

	typedef struct packed {
		logic t0_zero;
		logic t1_zero;
		logic ad_zero;
	} stat_t;

endpackage

@@ sv/rna_ctrl.sv @@
module rna_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [3:0]     mode,
	input  rna_pkg::stat_t stat,
	output rna_pkg::cmd_t  cmd,
	output logic           busy
);
	import rna_pkg::*;

	localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	state_t         state_q, state_d;
	mode_t          mode_q;
	logic [2:0]     step_q;
	logic [CW-1:0]  cnt_q;
	logic           err_q;
	logic           err_set;
	logic [2:0]     nsteps;
	logic           run_last;

	kind_t u_kind;
	src_t  u_sa, u_sb;
	dest_t u_dest;

	assign run_last = (cnt_q == CW'(DATA_WIDTH - 1));

	always_comb begin
		case (mode_q)
			MODE_ADD, MODE_SUB: nsteps = 3'd3;
			MODE_MUL, MODE_DIV: nsteps = 3'd2;
			MODE_REM:           nsteps = 3'd4;
			MODE_TRUNC, MODE_CEIL: nsteps = 3'd2;
			MODE_REDUCE:        nsteps = 3'd3;
			default:            nsteps = 3'd0;
		endcase
	end

	// operation list per mode
	always_comb begin
		u_kind = K_MUL;
		u_sa   = SRC_AN;
		u_sb   = SRC_BD;
		u_dest = D_T0;
		case (mode_q)
			MODE_ADD, MODE_SUB: begin
				case (step_q)
					3'd0: begin u_sa = SRC_AN; u_sb = SRC_BD; u_dest = D_T0; end
					3'd1: begin u_sa = SRC_AD; u_sb = SRC_BN; u_dest = D_T1; end
					default: begin u_sa = SRC_AD; u_sb = SRC_BD; u_dest = D_T2; end
				endcase
			end
			MODE_MUL: begin
				case (step_q)
					3'd0: begin u_sa = SRC_AN; u_sb = SRC_BN; u_dest = D_T0; end
					default: begin u_sa = SRC_AD; u_sb = SRC_BD; u_dest = D_T2; end
				endcase
			end
			MODE_DIV: begin
				case (step_q)
					3'd0: begin u_sa = SRC_AN; u_sb = SRC_BD; u_dest = D_T0; end
					default: begin u_sa = SRC_AD; u_sb = SRC_BN; u_dest = D_T2; end
				endcase
			end
			MODE_REM: begin
				case (step_q)
					3'd0: begin u_sa = SRC_AD; u_sb = SRC_BN; u_dest = D_T1; end
					3'd1: begin u_sa = SRC_BD; u_sb = SRC_AN; u_dest = D_T0; end
					3'd2: begin
						u_kind = K_SREM; u_sa = SRC_T0; u_sb = SRC_T1; u_dest = D_T0;
					end
					default: begin u_sa = SRC_AD; u_sb = SRC_BD; u_dest = D_T2; end
				endcase
			end
			MODE_TRUNC, MODE_CEIL: begin
				case (step_q)
					3'd0: begin
						u_kind = K_SDIV; u_sa = SRC_AN; u_sb = SRC_AD; u_dest = D_T0;
					end
					default: begin u_sa = SRC_T0; u_sb = SRC_AD; u_dest = D_T0; end
				endcase
			end
			MODE_REDUCE: begin
				case (step_q)
					3'd0: begin
						u_kind = K_UREM; u_sa = SRC_T0; u_sb = SRC_T1; u_dest = D_GCD;
					end
					3'd1: begin
						u_kind = K_QDIV; u_sa = SRC_AN; u_sb = SRC_T0; u_dest = D_T1;
					end
					default: begin
						u_kind = K_QDIV; u_sa = SRC_AD; u_sb = SRC_T0; u_dest = D_T2;
					end
				endcase
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		err_set = 1'b0;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_CHECK;
			ST_CHECK: begin
				if ((mode_q == MODE_TRUNC || mode_q == MODE_CEIL) && step_q == 3'd0
					&& stat.ad_zero) begin
					err_set = 1'b1;
					state_d = ST_FINISH;
				end else if (mode_q == MODE_REM && step_q == 3'd1 && stat.t1_zero) begin
					err_set = 1'b1;
					state_d = ST_FINISH;
				end else if (mode_q == MODE_REDUCE && step_q == 3'd0) begin
					if (stat.t1_zero && stat.t0_zero) begin
						err_set = 1'b1;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_ISSUE;
					end
				end else if (step_q == nsteps) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE:  state_d = ST_RUN;
			ST_RUN:    if (run_last) state_d = ST_SAVE;
			ST_SAVE:   state_d = ST_CHECK;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.mode   = mode_q;
		cmd.kind   = u_kind;
		cmd.sa     = u_sa;
		cmd.sb     = u_sb;
		cmd.dest   = u_dest;
		cmd.err    = err_q;
		busy       = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.load   = start;
			ST_ISSUE:  cmd.issue  = 1'b1;
			ST_RUN:    cmd.run    = 1'b1;
			ST_SAVE:   cmd.save   = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_ADD;
			step_q  <= '0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				mode_q <= mode_t'(mode);
				step_q <= '0;
				err_q  <= 1'b0;
			end
			if (err_set) err_q <= 1'b1;
			// reduce: finished gcd when divisor reaches zero
			if (state_q == ST_CHECK && mode_q == MODE_REDUCE && step_q == 3'd0
				&& stat.t1_zero && !stat.t0_zero)
				step_q <= 3'd1;
			if (state_q == ST_SAVE && !(mode_q == MODE_REDUCE && step_q == 3'd0))
				step_q <= step_q + 3'd1;
			if (state_q == ST_ISSUE) cnt_q <= '0;
			else if (state_q == ST_RUN) cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule

@@ sv/rna_dpath.sv @@
module rna_dpath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rna_pkg::cmd_t       cmd,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic signed [31:0]  b_den,
	output rna_pkg::stat_t      stat,
	output logic                done,
	output logic signed [31:0]  res_num,
	output logic signed [31:0]  res_den,
	output logic                is_zero,
	output logic                is_nan,
	output logic                is_inf,
	output logic                divide_error
);
	import rna_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0] an_q, ad_q, bn_q, bd_q, t0_q, t1_q, t2_q;
	logic [W-1:0] ua_q, ub_q, acc_q;
	logic         nneg_q, dneg_q, rnz_q, done_q;
	kind_t        kind_q;

	logic [W-1:0] x, y, mag_x, mag_y;
	logic [W:0]   r2, r2_sub;
	logic [W-1:0] q_s, r_s, save_v;
	logic [W-1:0] rn, rd;

	function automatic logic [W-1:0] sel(src_t s, logic [W-1:0] an, logic [W-1:0] ad,
		logic [W-1:0] bn, logic [W-1:0] bd, logic [W-1:0] t0, logic [W-1:0] t1);
		logic [W-1:0] v;
		case (s)
			SRC_AN:  v = an;
			SRC_AD:  v = ad;
			SRC_BN:  v = bn;
			SRC_BD:  v = bd;
			SRC_T0:  v = t0;
			SRC_T1:  v = t1;
			default: v = an;
		endcase
		return v;
	endfunction

	function automatic logic [W-1:0] mag(logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	assign x     = sel(cmd.sa, an_q, ad_q, bn_q, bd_q, t0_q, t1_q);
	assign y     = sel(cmd.sb, an_q, ad_q, bn_q, bd_q, t0_q, t1_q);
	assign mag_x = mag(x);
	assign mag_y = mag(y);

	assign r2     = {acc_q, ub_q[W-1]};
	assign r2_sub = r2 - {1'b0, ua_q};

	assign q_s = (nneg_q ^ dneg_q) ? (~ub_q + W'(1)) : ub_q;
	assign r_s = nneg_q ? (~acc_q + W'(1)) : acc_q;

	always_comb begin
		case (kind_q)
			K_MUL:          save_v = acc_q;
			K_SDIV, K_QDIV: save_v = q_s;
			K_SREM:         save_v = r_s;
			K_UREM:         save_v = acc_q;
			default:        save_v = acc_q;
		endcase
	end

	always_comb begin
		rn = an_q;
		rd = ad_q;
		case (cmd.mode)
			MODE_ADD:  begin rn = t0_q + t1_q; rd = t2_q; end
			MODE_SUB:  begin rn = t0_q - t1_q; rd = t2_q; end
			MODE_MUL, MODE_DIV, MODE_REM: begin rn = t0_q; rd = t2_q; end
			MODE_TRUNC: begin rn = t0_q; rd = ad_q; end
			MODE_CEIL: begin rn = rnz_q ? (t0_q + ad_q) : t0_q; rd = ad_q; end
			MODE_REDUCE: begin rn = t1_q; rd = t2_q; end
			MODE_ABS:  begin rn = mag(an_q); rd = mag(ad_q); end
			MODE_NEG:  begin rn = ~an_q + W'(1); rd = ~ad_q + W'(1); end
			MODE_INV:  begin rn = ad_q; rd = an_q; end
			default: ;
		endcase
		if (cmd.err) begin
			rn = '0;
			rd = W'(1);
		end
	end

	assign stat.t0_zero = (t0_q == '0);
	assign stat.t1_zero = (t1_q == '0);
	assign stat.ad_zero = (ad_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			an_q <= W'(a_num);
			ad_q <= W'(a_den);
			bn_q <= W'(b_num);
			bd_q <= W'(b_den);
			t0_q <= mag(W'(a_num));
			t1_q <= mag(W'(a_den));
		end
		if (cmd.issue) begin
			kind_q <= cmd.kind;
			acc_q  <= '0;
			case (cmd.kind)
				K_MUL: begin
					ua_q <= x; ub_q <= y; nneg_q <= 1'b0; dneg_q <= 1'b0;
				end
				K_SDIV, K_SREM: begin
					ub_q <= mag_x; ua_q <= mag_y; nneg_q <= x[W-1]; dneg_q <= y[W-1];
				end
				K_QDIV: begin
					ub_q <= mag_x; ua_q <= y; nneg_q <= x[W-1]; dneg_q <= 1'b0;
				end
				default: begin
					ub_q <= x; ua_q <= y; nneg_q <= 1'b0; dneg_q <= 1'b0;
				end
			endcase
		end
		if (cmd.run) begin
			if (kind_q == K_MUL) begin
				if (ub_q[0]) acc_q <= acc_q + ua_q;
				ua_q <= {ua_q[W-2:0], 1'b0};
				ub_q <= {1'b0, ub_q[W-1:1]};
			end else if (!r2_sub[W]) begin
				acc_q <= r2_sub[W-1:0];
				ub_q  <= {ub_q[W-2:0], 1'b1};
			end else begin
				acc_q <= r2[W-1:0];
				ub_q  <= {ub_q[W-2:0], 1'b0};
			end
		end
		if (cmd.save) begin
			if (kind_q == K_SDIV) rnz_q <= (acc_q != '0);
			case (cmd.dest)
				D_T0:    t0_q <= save_v;
				D_T1:    t1_q <= save_v;
				D_T2:    t2_q <= save_v;
				D_GCD: begin
					t0_q <= t1_q;
					t1_q <= save_v;
				end
				default: t0_q <= save_v;
			endcase
		end
		if (cmd.finish) begin
			res_num      <= 32'(signed'(rn));
			res_den      <= 32'(signed'(rd));
			is_zero      <= (rn == '0) && (rd != '0);
			is_nan       <= (rn == '0) && (rd == '0);
			is_inf       <= (rn != '0) && (rd == '0);
			divide_error <= cmd.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= cmd.finish;
	end

	assign done = done_q;

endmodule

@@ sv/rational_number_alu.sv @@
// Rational number ALU. Pulse start with mode and operands while busy is low; the
// result appears on res_num/res_den and the flags for exactly one cycle with
// done high, and must be taken then since it cannot be held off. busy stays
// high until the cycle done rises. Every multiply and divide runs on one shared
// shift-add / restoring-divide unit, one operation at a time: add/sub run three
// operations, mul/div two, rem four, trunc/ceil two, reduce one per Euclid step
// of the gcd and then two more, and abs/negate/invert none.
module rational_number_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         mode,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               done,
	output logic signed [31:0] res_num,
	output logic signed [31:0] res_den,
	output logic               is_zero,
	output logic               is_nan,
	output logic               is_inf,
	output logic               divide_error
);
	import rna_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rna_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rna_dpath #(.DATA_WIDTH(DATA_WIDTH)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.a_num        (a_num),
		.a_den        (a_den),
		.b_num        (b_num),
		.b_den        (b_den),
		.stat         (stat),
		.done         (done),
		.res_num      (res_num),
		.res_den      (res_den),
		.is_zero      (is_zero),
		.is_nan       (is_nan),
		.is_inf       (is_inf),
		.divide_error (divide_error)
	);

`ifndef SYNTHESIS
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy fell without a result");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_err_val: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_error) |-> (res_num == 32'sd0 && res_den == 32'sd1))
		else $error("divide error result not 0/1");
`endif

endmodule

@@ test/tb.sv @@
module tb;
	import rna_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [31:0] MIN_VAL = 32'h8000_0000;
	localparam logic [31:0] MAX_VAL = 32'h7fff_ffff;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] mode;
	logic signed [31:0] a_num, a_den, b_num, b_den;
	logic done;
	logic signed [31:0] res_num, res_den;
	logic is_zero, is_nan, is_inf, divide_error;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		logic zero;
		logic nan;
		logic inf;
		logic derr;
	} frac_res_t;

	typedef struct {
		logic [3:0] md;
		logic [31:0] an, ad, bn, bd;
		logic has_exp;
		frac_res_t exp_res;
	} req_row_t;

	frac_res_t pending_q[$];
	int mismatches;
	int idle_cycles;
	bit timed_out;

	rational_number_alu u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.done(done), .res_num(res_num), .res_den(res_den), .is_zero(is_zero),
		.is_nan(is_nan), .is_inf(is_inf), .divide_error(divide_error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] mag32(logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	// truncating signed divide; d nonzero
	function automatic void sdiv32(logic [31:0] n, logic [31:0] d,
			output logic [31:0] q, output logic [31:0] r);
		logic [31:0] mq, mr;
		mq = mag32(n) / mag32(d);
		mr = mag32(n) % mag32(d);
		q = (n[31] != d[31]) ? -mq : mq;
		r = n[31] ? -mr : mr;
	endfunction

	function automatic frac_res_t predict_fraction(logic [3:0] md, logic [31:0] an,
			logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
		frac_res_t res;
		logic [31:0] rn, rd, q, r, dv, g, x, y, t;
		logic err;
		rn = an;
		rd = ad;
		err = 1'b0;
		case (md)
			MODE_ADD: begin
				rn = an * bd + ad * bn;
				rd = ad * bd;
			end
			MODE_SUB: begin
				rn = an * bd - ad * bn;
				rd = ad * bd;
			end
			MODE_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			MODE_DIV: begin
				rn = an * bd;
				rd = ad * bn;
			end
			MODE_REM: begin
				dv = ad * bn;
				if (dv == 0) err = 1'b1;
				else begin
					sdiv32(bd * an, dv, q, r);
					rn = r;
					rd = ad * bd;
				end
			end
			MODE_TRUNC, MODE_CEIL: begin
				if (ad == 0) err = 1'b1;
				else begin
					sdiv32(an, ad, q, r);
					rn = q * ad;
					if (md == MODE_CEIL && rn != an) rn = rn + ad;
					rd = ad;
				end
			end
			MODE_REDUCE: begin
				x = mag32(an);
				y = mag32(ad);
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				g = x;
				if (g == 0) err = 1'b1;
				else begin
					rn = an[31] ? -(mag32(an) / g) : mag32(an) / g;
					rd = ad[31] ? -(mag32(ad) / g) : mag32(ad) / g;
				end
			end
			MODE_ABS: begin
				rn = mag32(an);
				rd = mag32(ad);
			end
			MODE_NEG: begin
				rn = -an;
				rd = -ad;
			end
			MODE_INV: begin
				rn = ad;
				rd = an;
			end
			default: ;
		endcase
		if (err) begin
			rn = 0;
			rd = 1;
		end
		res.num = rn;
		res.den = rd;
		res.zero = (rn == 0) && (rd != 0);
		res.nan = (rn == 0) && (rd == 0);
		res.inf = (rn != 0) && (rd == 0);
		res.derr = err;
		return res;
	endfunction

	function automatic frac_res_t typed_res(logic [31:0] n, logic [31:0] d, logic e);
		frac_res_t res;
		res.num = n;
		res.den = d;
		res.zero = (n == 0) && (d != 0);
		res.nan = (n == 0) && (d == 0);
		res.inf = (n != 0) && (d == 0);
		res.derr = e;
		return res;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return MIN_VAL;
			1: return MAX_VAL;
			2: return 32'(int'($urandom_range(0, 2)) - 1);
			3, 4: return 32'(int'($urandom_range(0, 40)) - 20);
			5, 6: return 32'(int'($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	// outputs checked at rising edge
	always @(posedge clk) begin
		frac_res_t got, want;
		if (arst_n && done) begin
			got = {res_num, res_den, is_zero, is_nan, is_inf, divide_error};
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h/%h", res_num, res_den);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h/%h z%b n%b i%b e%b got %h/%h z%b n%b i%b e%b",
							want.num, want.den, want.zero, want.nan, want.inf, want.derr,
							got.num, got.den, got.zero, got.nan, got.inf, got.derr);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	// busy covers the negedge after acceptance, so the added negedge wait costs no rate
	task automatic send_request(logic [3:0] md, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd, logic has_exp, frac_res_t exp_res);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap + 1) @(negedge clk);
		start <= 1'b1;
		mode <= md;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
		pending_q.push_back(has_exp ? exp_res : predict_fraction(md, an, ad, bn, bd));
		@(negedge clk);
		start <= 1'b0;
	endtask

	req_row_t dir_rows[$];

	task automatic add_row(logic [3:0] md, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd, logic has_exp, frac_res_t exp_res);
		req_row_t row;
		row.md = md;
		row.an = an;
		row.ad = ad;
		row.bn = bn;
		row.bd = bd;
		row.has_exp = has_exp;
		row.exp_res = exp_res;
		dir_rows.push_back(row);
	endtask

	initial begin
		frac_res_t none;
		logic [3:0] md;
		none = '0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = '0;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;

		add_row(MODE_ADD, 1, 2, 1, 3, 1, typed_res(5, 6, 0));
		add_row(MODE_SUB, 1, 2, 1, 2, 1, typed_res(0, 4, 0));
		add_row(MODE_MUL, MAX_VAL, MAX_VAL, MIN_VAL, MIN_VAL, 0, none);
		add_row(MODE_DIV, 3, 4, 0, 5, 1, typed_res(15, 0, 0));
		add_row(MODE_DIV, 0, 4, 0, 5, 1, typed_res(0, 0, 0));
		add_row(MODE_REM, 7, 1, 0, 1, 1, typed_res(0, 1, 1));
		add_row(MODE_REM, MIN_VAL, 1, -1, 1, 1, typed_res(0, 1, 0));
		add_row(MODE_REM, -7, 2, 3, 5, 0, none);
		add_row(MODE_TRUNC, 7, 0, 0, 0, 1, typed_res(0, 1, 1));
		add_row(MODE_TRUNC, -7, 2, 0, 0, 1, typed_res(-6, 2, 0));
		add_row(MODE_TRUNC, MIN_VAL, -1, 0, 0, 1, typed_res(MIN_VAL, -1, 0));
		add_row(MODE_CEIL, 7, 2, 0, 0, 1, typed_res(8, 2, 0));
		add_row(MODE_CEIL, 6, 2, 0, 0, 1, typed_res(6, 2, 0));
		add_row(MODE_CEIL, 5, 0, 0, 0, 1, typed_res(0, 1, 1));
		add_row(MODE_REDUCE, 0, 0, 0, 0, 1, typed_res(0, 1, 1));
		add_row(MODE_REDUCE, -12, 18, 0, 0, 1, typed_res(-2, 3, 0));
		add_row(MODE_REDUCE, MIN_VAL, MIN_VAL, 0, 0, 1, typed_res(-1, -1, 0));
		add_row(MODE_REDUCE, 5, 0, 0, 0, 1, typed_res(1, 0, 0));
		add_row(MODE_ABS, MIN_VAL, -5, 0, 0, 1, typed_res(MIN_VAL, 5, 0));
		add_row(MODE_NEG, MIN_VAL, MAX_VAL, 0, 0, 1, typed_res(MIN_VAL, -MAX_VAL, 0));
		add_row(MODE_INV, 0, 9, 0, 0, 1, typed_res(9, 0, 0));
		add_row(4'd11, 3, 4, 5, 6, 1, typed_res(3, 4, 0));
		add_row(4'd15, -1, -1, -1, -1, 1, typed_res(-1, -1, 0));
		add_row(MODE_ADD, -1, -1, -1, -1, 0, none);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].md, dir_rows[i].an, dir_rows[i].ad, dir_rows[i].bn,
				dir_rows[i].bd, dir_rows[i].has_exp, dir_rows[i].exp_res);

		for (int n = 0; n < 850; n++) begin
			md = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			send_request(md, rand_operand(), rand_operand(), rand_operand(), rand_operand(),
				0, none);
		end

		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
